>>> sv/delaunay_incircle_test_unit_defines.svh
// Assertion macros for the incircle test unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef DELAUNAY_INCIRCLE_TEST_UNIT_DEFINES_SVH
`define DELAUNAY_INCIRCLE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dit_pkg.sv
// Shared widths, types and sign codes for the incircle test unit.
// No dependencies.
package dit_pkg;

  localparam int FIELD_W    = 16;            // width of a coordinate field
  localparam int COORD_BITS = 16;            // bits of a field that are used (4..FIELD_W)
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int LO_W       = DIFF_W;
  localparam int HI_W       = SUM_W - LO_W;
  localparam int PLO_W      = LO_W + 1 + SUM_W;
  localparam int PHI_W      = HI_W + SUM_W;
  localparam int TERM_W     = 2 * SUM_W;
  localparam int ACC_W      = TERM_W + 2;
  localparam int N_STAGES   = 6;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [PLO_W-1:0]   plo_t;
  typedef logic signed [PHI_W-1:0]   phi_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [1:0]         sign_t;

  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_POS  = 2'sb01;
  localparam sign_t SIGN_BAD  = 2'sb10;
  localparam sign_t SIGN_NEG  = 2'sb11;

  // load enables of the two register stages inside one module
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } stage_ld_t;

endpackage

>>> sv/dit_in_if.sv
// Input channel: triangle corners, query point and infinite-face flag.
// Depends on dit_pkg.
interface dit_in_if;
  import dit_pkg::*;

  logic   valid;
  logic   ready;
  coord_t corner_a_x;
  coord_t corner_a_y;
  coord_t corner_b_x;
  coord_t corner_b_y;
  coord_t corner_c_x;
  coord_t corner_c_y;
  coord_t query_x;
  coord_t query_y;
  logic   face_infinite;

  modport source (
    output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           corner_c_x, corner_c_y, query_x, query_y, face_infinite,
    input  ready
  );
  modport sink (
    input  valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           corner_c_x, corner_c_y, query_x, query_y, face_infinite,
    output ready
  );
endinterface

>>> sv/dit_out_if.sv
// Result channel: inside flag and combined sign.
// Depends on dit_pkg.
interface dit_out_if;
  import dit_pkg::*;

  logic  valid;
  logic  ready;
  logic  inside_circle;
  sign_t combined_sign;

  modport source (output valid, inside_circle, combined_sign, input ready);
  modport sink (input valid, inside_circle, combined_sign, output ready);
endinterface

>>> sv/delaunay_incircle_test_unit.sv
// Exact 2D Delaunay incircle predicate, six-stage pipeline.
// Throughput: one beat per cycle; each stage holds while the one after it is full and cannot move on.
// Stall: ready ripples back per stage, so bubbles are squeezed out during a stall.
// Reset (synchronous, active low) clears the stage valid bits only.
`include "delaunay_incircle_test_unit_defines.svh"

module delaunay_incircle_test_unit (
  input  logic        clk,
  input  logic        rst_n,
  dit_in_if.sink      in_if,
  dit_out_if.source   out_if
);
  import dit_pkg::*;

  logic [N_STAGES-1:0] valid_r, valid_nxt;
  logic [N_STAGES-1:0] ld;

  prod_t sq [6];
  prod_t mn [6];
  plo_t  plo [3];
  phi_t  phi [3];
  logic  face_1, face_3;
  logic  bc_zero_3, bc_neg_3;
  logic  inside_5;
  sign_t sign_5;

  stage_ld_t ld_diff, ld_lift, ld_acc;

  // a stage loads when it is empty or its content moves on this cycle
  always_comb begin
    ld[N_STAGES-1] = ~valid_r[N_STAGES-1] | out_if.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      ld[k] = ~valid_r[k] | ld[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ld[0]) begin
      valid_nxt[0] = in_if.valid;
    end
    for (int k = 1; k < N_STAGES; k++) begin
      if (ld[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ld_diff = '{ld_a: ld[0], ld_b: ld[1]};
  assign ld_lift = '{ld_a: ld[2], ld_b: ld[3]};
  assign ld_acc  = '{ld_a: ld[4], ld_b: ld[5]};

  dit_diff u_diff (
    .clk     (clk),
    .ld      (ld_diff),
    .ax      (in_if.corner_a_x),
    .ay      (in_if.corner_a_y),
    .bx      (in_if.corner_b_x),
    .by      (in_if.corner_b_y),
    .cx      (in_if.corner_c_x),
    .cy      (in_if.corner_c_y),
    .px      (in_if.query_x),
    .py      (in_if.query_y),
    .face_in (in_if.face_infinite),
    .sq_r    (sq),
    .mn_r    (mn),
    .face_r  (face_1)
  );

  dit_lift u_lift (
    .clk       (clk),
    .ld        (ld_lift),
    .sq        (sq),
    .mn        (mn),
    .face_in   (face_1),
    .plo_r     (plo),
    .phi_r     (phi),
    .bc_zero_r (bc_zero_3),
    .bc_neg_r  (bc_neg_3),
    .face_r    (face_3)
  );

  dit_acc u_acc (
    .clk      (clk),
    .ld       (ld_acc),
    .plo      (plo),
    .phi      (phi),
    .bc_zero  (bc_zero_3),
    .bc_neg   (bc_neg_3),
    .face_in  (face_3),
    .inside_r (inside_5),
    .sign_r   (sign_5)
  );

  assign in_if.ready          = ld[0];
  assign out_if.valid         = valid_r[N_STAGES-1];
  assign out_if.inside_circle = inside_5;
  assign out_if.combined_sign = sign_5;

  `DIT_ASSERT_IMP(a_stall_only_when_full, !in_if.ready, valid_r[0], "input stalled with empty entry stage")
  `DIT_ASSERT_NXT(a_accept_fills_entry, in_if.valid && in_if.ready, valid_r[0], "accepted beat not in entry stage")
  `DIT_ASSERT_IMP(a_pos_is_outside, out_if.valid && (out_if.combined_sign == SIGN_POS), !out_if.inside_circle, "positive sign flagged inside")
  `DIT_ASSERT_IMP(a_sign_code_legal, out_if.valid, (out_if.combined_sign != SIGN_BAD) && ((out_if.combined_sign != SIGN_NEG) || out_if.inside_circle), "illegal sign code or negative sign outside")

endmodule

>>> sv/dit_diff.sv
// Stages 0 and 1: offsets from corner a, then squares and minor products.
// Depends on dit_pkg.
module dit_diff (
  input  logic                clk,
  input  dit_pkg::stage_ld_t  ld,
  input  dit_pkg::coord_t     ax,
  input  dit_pkg::coord_t     ay,
  input  dit_pkg::coord_t     bx,
  input  dit_pkg::coord_t     by,
  input  dit_pkg::coord_t     cx,
  input  dit_pkg::coord_t     cy,
  input  dit_pkg::coord_t     px,
  input  dit_pkg::coord_t     py,
  input  logic                face_in,
  output dit_pkg::prod_t      sq_r [6],
  output dit_pkg::prod_t      mn_r [6],
  output logic                face_r
);
  import dit_pkg::*;

  diff_t dbx_r, dby_r, dcx_r, dcy_r, dpx_r, dpy_r;
  logic  face_a_r;

  // only the low COORD_BITS of a field count, sign-extended
  function automatic diff_t coord_of(input coord_t f);
    logic signed [COORD_BITS-1:0] v;
    v = f[COORD_BITS-1:0];
    return DIFF_W'(v);
  endfunction

  function automatic prod_t mul(input diff_t a, input diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      dbx_r    <= coord_of(bx) - coord_of(ax);
      dby_r    <= coord_of(by) - coord_of(ay);
      dcx_r    <= coord_of(cx) - coord_of(ax);
      dcy_r    <= coord_of(cy) - coord_of(ay);
      dpx_r    <= coord_of(px) - coord_of(ax);
      dpy_r    <= coord_of(py) - coord_of(ay);
      face_a_r <= face_in;
    end
  end

  // squares: b x/y, c x/y, p x/y; minors: cp, bp, bc pairs
  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      sq_r[0] <= mul(dbx_r, dbx_r);
      sq_r[1] <= mul(dby_r, dby_r);
      sq_r[2] <= mul(dcx_r, dcx_r);
      sq_r[3] <= mul(dcy_r, dcy_r);
      sq_r[4] <= mul(dpx_r, dpx_r);
      sq_r[5] <= mul(dpy_r, dpy_r);
      mn_r[0] <= mul(dcx_r, dpy_r);
      mn_r[1] <= mul(dpx_r, dcy_r);
      mn_r[2] <= mul(dbx_r, dpy_r);
      mn_r[3] <= mul(dpx_r, dby_r);
      mn_r[4] <= mul(dbx_r, dcy_r);
      mn_r[5] <= mul(dcx_r, dby_r);
      face_r  <= face_a_r;
    end
  end
endmodule

>>> sv/dit_lift.sv
// Stages 2 and 3: lifted norms and 2x2 minors, then split partial products.
// Depends on dit_pkg.
module dit_lift (
  input  logic                clk,
  input  dit_pkg::stage_ld_t  ld,
  input  dit_pkg::prod_t      sq [6],
  input  dit_pkg::prod_t      mn [6],
  input  logic                face_in,
  output dit_pkg::plo_t       plo_r [3],
  output dit_pkg::phi_t       phi_r [3],
  output logic                bc_zero_r,
  output logic                bc_neg_r,
  output logic                face_r
);
  import dit_pkg::*;

  sum_t lb_r, lc_r, lp_r, mcp_r, mbp_r, mbc_r;
  logic face_a_r;

  // norm is non-negative: low LO_W bits unsigned, the rest signed
  function automatic plo_t mul_lo(input sum_t l, input sum_t m);
    logic signed [LO_W:0] lo;
    lo = {1'b0, l[LO_W-1:0]};
    return plo_t'(lo) * plo_t'(m);
  endfunction

  function automatic phi_t mul_hi(input sum_t l, input sum_t m);
    logic signed [HI_W-1:0] hi;
    hi = l[SUM_W-1:LO_W];
    return phi_t'(hi) * phi_t'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      lb_r     <= sum_t'(sq[0]) + sum_t'(sq[1]);
      lc_r     <= sum_t'(sq[2]) + sum_t'(sq[3]);
      lp_r     <= sum_t'(sq[4]) + sum_t'(sq[5]);
      mcp_r    <= sum_t'(mn[0]) - sum_t'(mn[1]);
      mbp_r    <= sum_t'(mn[2]) - sum_t'(mn[3]);
      mbc_r    <= sum_t'(mn[4]) - sum_t'(mn[5]);
      face_a_r <= face_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      plo_r[0]  <= mul_lo(lb_r, mcp_r);
      phi_r[0]  <= mul_hi(lb_r, mcp_r);
      plo_r[1]  <= mul_lo(lc_r, mbp_r);
      phi_r[1]  <= mul_hi(lc_r, mbp_r);
      plo_r[2]  <= mul_lo(lp_r, mbc_r);
      phi_r[2]  <= mul_hi(lp_r, mbc_r);
      bc_zero_r <= (mbc_r == '0);
      bc_neg_r  <= mbc_r[SUM_W-1];
      face_r    <= face_a_r;
    end
  end
endmodule

>>> sv/dit_acc.sv
// Stages 4 and 5: rebuild the three determinant terms, sum them, take signs.
// Depends on dit_pkg.
module dit_acc (
  input  logic                clk,
  input  dit_pkg::stage_ld_t  ld,
  input  dit_pkg::plo_t       plo [3],
  input  dit_pkg::phi_t       phi [3],
  input  logic                bc_zero,
  input  logic                bc_neg,
  input  logic                face_in,
  output logic                inside_r,
  output dit_pkg::sign_t      sign_r
);
  import dit_pkg::*;

  term_t tb_r, tc_r, tp_r;
  logic  bc_zero_a_r, bc_neg_a_r, face_a_r;
  acc_t  acc;
  sign_t sign_nxt;
  logic  inside_nxt;

  function automatic term_t join_term(input phi_t h, input plo_t l);
    return (term_t'(h) <<< LO_W) + term_t'(l);
  endfunction

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      tb_r        <= join_term(phi[0], plo[0]);
      tc_r        <= join_term(phi[1], plo[1]);
      tp_r        <= join_term(phi[2], plo[2]);
      bc_zero_a_r <= bc_zero;
      bc_neg_a_r  <= bc_neg;
      face_a_r    <= face_in;
    end
  end

  // determinant = lb*m_cp - lc*m_bp + lp*m_bc
  always_comb begin
    acc = acc_t'(tb_r) - acc_t'(tc_r) + acc_t'(tp_r);
    if (face_a_r || bc_zero_a_r || (acc == '0)) begin
      sign_nxt = SIGN_ZERO;
    end else if (acc[ACC_W-1] ^ bc_neg_a_r) begin
      sign_nxt = SIGN_NEG;
    end else begin
      sign_nxt = SIGN_POS;
    end
    inside_nxt = !face_a_r && (sign_nxt != SIGN_POS);
  end

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      sign_r   <= sign_nxt;
      inside_r <= inside_nxt;
    end
  end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for delaunay_incircle_test_unit: drives triangle/query beats and checks each verdict
// against an exact 128-bit incircle and orientation computation. Depends on dit_pkg, dit_in_if,
// dit_out_if and the unit itself.
module testbench;
  import dit_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 4 * N_STAGES;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t query_x;
    coord_t query_y;
    logic   face_infinite;
  } tri_query_t;

  typedef struct packed {
    logic  inside_circle;
    sign_t combined_sign;
  } verdict_t;

  // Holds the verdicts owed by the unit, oldest first, and scores the ones it delivers.
  class verdict_tracker;
    verdict_t due_verdicts[$];
    int mismatches;
    int checked;
    int inside_due;
    int infinite_seen;

    // low COORD_BITS of a field, sign-extended
    function wide_t widen(coord_t c);
      return {{(128-COORD_BITS){c[COORD_BITS-1]}}, c[COORD_BITS-1:0]};
    endfunction

    function int sign_of(wide_t v);
      return (v == 0) ? 0 : ((v < 0) ? -1 : 1);
    endfunction

    function verdict_t predict_verdict(tri_query_t q);
      wide_t ax, ay, dbx, dby, dcx, dcy, dpx, dpy;
      wide_t lb, lc, lp, m_cp, m_bp, m_bc, det;
      int s_prod;
      verdict_t v;
      if (q.face_infinite) begin
        v.inside_circle = 1'b0;
        v.combined_sign = SIGN_ZERO;
        return v;
      end
      ax  = widen(q.corner_a_x);
      ay  = widen(q.corner_a_y);
      dbx = widen(q.corner_b_x) - ax;
      dby = widen(q.corner_b_y) - ay;
      dcx = widen(q.corner_c_x) - ax;
      dcy = widen(q.corner_c_y) - ay;
      dpx = widen(q.query_x) - ax;
      dpy = widen(q.query_y) - ay;
      lb = dbx * dbx + dby * dby;
      lc = dcx * dcx + dcy * dcy;
      lp = dpx * dpx + dpy * dpy;
      m_cp = dcx * dpy - dpx * dcy;
      m_bp = dbx * dpy - dpx * dby;
      m_bc = dbx * dcy - dcx * dby;
      det = lb * m_cp - lc * m_bp + lp * m_bc;
      s_prod = sign_of(det) * sign_of(m_bc);
      v.inside_circle = (s_prod <= 0);
      v.combined_sign = (s_prod > 0) ? SIGN_POS : ((s_prod < 0) ? SIGN_NEG : SIGN_ZERO);
      return v;
    endfunction

    function void note_query(tri_query_t q);
      verdict_t v;
      v = predict_verdict(q);
      due_verdicts.push_back(v);
      if (v.inside_circle) inside_due++;
      if (q.face_infinite) infinite_seen++;
    endfunction

    function void check_verdict(logic inside_got, sign_t sgn);
      verdict_t want;
      checked++;
      if (due_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat %0d with no verdict due: inside=%0b sign=%0d",
                   checked, inside_got, sgn);
        return;
      end
      want = due_verdicts.pop_front();
      if (inside_got !== want.inside_circle || sgn !== want.combined_sign) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat %0d: expected inside=%0b sign=%0d, got inside=%0b sign=%0d",
                   checked, want.inside_circle, want.combined_sign, inside_got, sgn);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_left = 0;
  int   cycle_count = 0;
  verdict_tracker tracker = new();

  dit_in_if  in_ch ();
  dit_out_if out_ch ();

  delaunay_incircle_test_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts still due",
               cycle_count, tracker.due_verdicts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_verdict(out_ch.inside_circle, out_ch.combined_sign);
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_query(input tri_query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.corner_a_x    <= q.corner_a_x;
    in_ch.corner_a_y    <= q.corner_a_y;
    in_ch.corner_b_x    <= q.corner_b_x;
    in_ch.corner_b_y    <= q.corner_b_y;
    in_ch.corner_c_x    <= q.corner_c_x;
    in_ch.corner_c_y    <= q.corner_c_y;
    in_ch.query_x       <= q.query_x;
    in_ch.query_y       <= q.query_y;
    in_ch.face_infinite <= q.face_infinite;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_query(q);
  endtask

  function automatic tri_query_t make_query(int ax, int ay, int bx, int by,
                                            int cx, int cy, int px, int py, bit inf);
    tri_query_t q;
    q.corner_a_x    = coord_t'(ax);
    q.corner_a_y    = coord_t'(ay);
    q.corner_b_x    = coord_t'(bx);
    q.corner_b_y    = coord_t'(by);
    q.corner_c_x    = coord_t'(cx);
    q.corner_c_y    = coord_t'(cy);
    q.query_x       = coord_t'(px);
    q.query_y       = coord_t'(py);
    q.face_infinite = inf;
    return q;
  endfunction

  function automatic coord_t jitter(coord_t c);
    return coord_t'(c + $urandom_range(16) - 8);
  endfunction

  // Mostly structured shapes: clustered points hit degenerate and cocircular cases,
  // rectangle corners are exactly cocircular, nudged by up to eight they land just off the circle.
  function automatic tri_query_t random_query();
    tri_query_t q;
    logic [5*32-1:0] raw;
    coord_t cx0, cy0, x0, y0;
    coord_t rx[4];
    coord_t ry[4];
    int kind, r, w, h;
    kind = $urandom_range(99);
    q = '0;
    if (kind < 35 || kind >= 90) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(tri_query_t)-1:0];
      q.face_infinite = (kind >= 90);
    end else if (kind < 65) begin
      cx0 = coord_t'($urandom);
      cy0 = coord_t'($urandom);
      q.corner_a_x = jitter(cx0);
      q.corner_a_y = jitter(cy0);
      q.corner_b_x = jitter(cx0);
      q.corner_b_y = jitter(cy0);
      q.corner_c_x = jitter(cx0);
      q.corner_c_y = jitter(cy0);
      q.query_x    = jitter(cx0);
      q.query_y    = jitter(cy0);
    end else begin
      w  = ($urandom_range(3) == 0) ? $urandom_range(30000) : $urandom_range(40);
      h  = ($urandom_range(3) == 0) ? $urandom_range(30000) : $urandom_range(40);
      x0 = coord_t'($urandom_range(65535 - w) - 32768);
      y0 = coord_t'($urandom_range(65535 - h) - 32768);
      rx = '{x0, coord_t'(x0 + w), coord_t'(x0 + w), x0};
      ry = '{y0, y0, coord_t'(y0 + h), coord_t'(y0 + h)};
      r  = $urandom_range(3);
      q.corner_a_x = rx[r];
      q.corner_a_y = ry[r];
      q.corner_b_x = rx[(r + 1) % 4];
      q.corner_b_y = ry[(r + 1) % 4];
      q.corner_c_x = rx[(r + 2) % 4];
      q.corner_c_y = ry[(r + 2) % 4];
      q.query_x    = rx[(r + 3) % 4];
      q.query_y    = ry[(r + 3) % 4];
      if ($urandom_range(1)) begin
        q.corner_b_x = rx[(r + 3) % 4];
        q.corner_b_y = ry[(r + 3) % 4];
        q.query_x    = rx[(r + 1) % 4];
        q.query_y    = ry[(r + 1) % 4];
      end
      if ($urandom_range(2) == 0) q.query_x = jitter(q.query_x);
    end
    return q;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_query(random_query());
  endtask

  initial begin
    rst_n               = 1'b0;
    send_idle_pct       = 10;
    recv_idle_pct       = 66;
    out_ch.ready        = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.corner_a_x    = '0;
    in_ch.corner_a_y    = '0;
    in_ch.corner_b_x    = '0;
    in_ch.corner_b_y    = '0;
    in_ch.corner_c_x    = '0;
    in_ch.corner_c_y    = '0;
    in_ch.query_x       = '0;
    in_ch.query_y       = '0;
    in_ch.face_infinite = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, orientations, on-circle, degenerate and infinite faces
    send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0));
    send_query(make_query(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 0));
    send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 0));
    send_query(make_query(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768, 0));
    send_query(make_query(-32768, -32768, 32767, -32768, 0, 32767, 0, 0, 0));
    send_query(make_query(-32768, -32768, 0, 32767, 32767, -32768, 0, 0, 0));
    send_query(make_query(0, 0, 1, 0, 0, 1, 32767, 32767, 0));
    send_query(make_query(0, 0, 0, 1, 1, 0, -32768, -32768, 0));
    send_query(make_query(0, 0, 10, 0, 0, 10, 3, 3, 0));
    send_query(make_query(0, 0, 0, 10, 10, 0, 3, 3, 0));
    send_query(make_query(0, 0, 5, 5, 10, 10, 1, 2, 0));
    send_query(make_query(7, -3, 7, -3, 20, 9, 8, 8, 0));
    send_query(make_query(7, -3, 12, 40, -20, 9, 7, -3, 0));
    send_query(make_query(0, 0, 4, 0, 4, 4, 0, 4, 0));
    send_query(make_query(0, 0, 4, 0, 4, 4, 0, 5, 0));
    send_query(make_query(0, 0, 4, 0, 4, 4, 1, 3, 0));
    send_query(make_query(0, 0, 10, 0, 0, 10, 3, 3, 1));
    send_query(make_query(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 1));
    send_query(make_query(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845, 0));
    send_query(make_query(21845, -21846, -21846, 21845, 21845, 21845, -21846, 0, 0));
    send_query(make_query(-32768, 0, 32767, 0, 0, 32767, 0, -32767, 0));

    send_random(RANDOM_ITEMS / 3);

    send_idle_pct = 66;
    recv_idle_pct = 10;
    send_random(RANDOM_ITEMS / 3);

    // no idling; receiver blocks for a long stretch so the pipeline fills and backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left <= HOLD_CYCLES;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    in_ch.valid <= 1'b0;

    while (tracker.due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d verdicts: %0d expected inside, %0d infinite faces, %0d mismatches.",
             tracker.checked, tracker.inside_due, tracker.infinite_seen, tracker.mismatches);
    $display("Stimulus: field extremes, on-circle, degenerate, clustered and random triangles.");
    if (tracker.mismatches == 0 && tracker.due_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
